// File: src/tate_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tate_pkg: shared types and constants of the temperature alarm panel
// Function codes, panel modes, limit defaults and digit helpers.
// ----------------------------------------------------------------------------
package tate_pkg;

  localparam int unsigned FuncW     = 3;
  localparam int unsigned TempW     = 18;
  localparam int unsigned DegW      = 8;   // whole degrees, at most 131
  localparam int unsigned ValW      = 7;   // displayed number and limits
  localparam int unsigned DigitW    = 4;
  localparam int unsigned InDataW   = 24;  // pressed + temp_milli, byte-padded
  localparam int unsigned OutDataW  = 16;  // result fields, byte-padded

  // Division by 1000 as a multiply by a rounded-up reciprocal and a shift.
  // Exact for every magnitude up to 2^17.
  localparam int unsigned Div1000Shift = 27;
  localparam logic [TempW-1:0] Div1000Mul = 18'd134218;

  localparam logic [ValW-1:0] LimitHighRst = 7'd30;
  localparam logic [ValW-1:0] LimitLowRst  = 7'd25;
  localparam logic [ValW-1:0] DisplayMax   = 7'd99;
  localparam logic [DigitW-1:0] DigitMax   = 4'd9;

  typedef enum logic [FuncW-1:0] {
    FUNC_SAMPLE   = 3'd0,
    FUNC_MODE_KEY = 3'd1,
    FUNC_INC_KEY  = 3'd2,
    FUNC_SEL_KEY  = 3'd3,
    FUNC_DEC_KEY  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_EDIT_HIGH = 2'd1,
    MODE_EDIT_LOW  = 2'd2
  } mode_e;

  // Tens digit of a value in 0..99: multiply by 205 and shift by 11.
  function automatic logic [DigitW-1:0] tens_of(input logic [ValW-1:0] val);
    logic [17:0] prod;
    prod = {11'd0, val} * 18'd205;
    return prod[14:11];
  endfunction

  // Two digits back into a value: tens * 10 + ones.
  function automatic logic [ValW-1:0] join_digits(input logic [DigitW-1:0] tens,
                                                  input logic [DigitW-1:0] ones);
    logic [ValW-1:0] t;
    t = {3'd0, tens};
    return (t << 3) + (t << 1) + {3'd0, ones};
  endfunction

endpackage

// File: src/temp_alarm_threshold_editor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_alarm_threshold_editor_top: temperature alarm with limit editing panel
// Takes temperature samples and key presses, keeps the limits and the panel
// state, and returns one status transfer per input transfer.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                        | tuser
//  s_axis   | in        | pressed, temp_milli[17:0], pad            | func[2:0]
//  m_axis   | out       | display_value[6:0], display_updated,      | -
//           |           | edit_mode[1:0], blink_digit, blink_on,    |
//           |           | led_a, led_b, alarm, pad                  |
//
// One transfer per cycle in, one per cycle out, while m_axis does not stall.
// The first stage registers the sample in whole degrees (the divide by 1000
// is one 18x18 multiply); the second stage applies the item to the panel
// state and loads the result register.
// Reset (rst_ni low) returns to normal mode with limits 30 and 25.
// A stall on m_axis holds both stages; s_axis_tready drops once the first stage is full.
// ----------------------------------------------------------------------------
module temp_alarm_threshold_editor_top
  import tate_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // pressed, temp_milli[17:0], pad
  input  logic [FuncW-1:0]    s_axis_tuser,   // func[2:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // display_value[6:0], display_updated,
                                              // edit_mode[1:0], blink_digit, blink_on,
                                              // led_a, led_b, alarm, pad
);

  // ---------------- input stage ----------------
  logic              in_valid_q;
  logic [FuncW-1:0]  func_q;
  logic              pressed_q;
  logic [DegW-1:0]   deg_q;
  logic              advance;

  logic [TempW-1:0]   temp_raw;
  logic [TempW-1:0]   temp_mag;
  logic [2*TempW-1:0] deg_prod;
  logic [DegW-1:0]    deg_d;

  assign temp_raw = s_axis_tdata[TempW:1];
  assign temp_mag = temp_raw[TempW-1] ? (~temp_raw + 18'd1) : temp_raw;
  assign deg_prod = temp_mag * Div1000Mul;
  assign deg_d    = deg_prod[Div1000Shift +: DegW];

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q    <= s_axis_tuser;
      pressed_q <= s_axis_tdata[0];
      deg_q     <= deg_d;
    end
  end

  // ---------------- panel state ----------------
  mode_e           mode_q, mode_d;
  logic            digit_sel_q, digit_sel_d;
  logic [ValW-1:0] limit_high_q, limit_high_d;
  logic [ValW-1:0] limit_low_q, limit_low_d;
  logic [ValW-1:0] shown_q, shown_d;
  logic            led_a_q, led_a_d;
  logic            led_b_q, led_b_d;
  logic            buzzer_q, buzzer_d;
  logic            upd;

  logic [ValW-1:0]   cur;
  logic [DigitW-1:0] cur_tens, cur_ones, new_tens, new_ones, sel_digit, step_digit;
  logic [ValW-1:0]   cand;
  logic              step_up;

  always_comb begin
    cur       = (mode_q == MODE_EDIT_HIGH) ? limit_high_q : limit_low_q;
    cur_tens  = tens_of(cur);
    cur_ones  = DigitW'(cur - join_digits(cur_tens, 4'd0));
    step_up   = (func_e'(func_q) == FUNC_INC_KEY);
    sel_digit = digit_sel_q ? cur_ones : cur_tens;
    if (step_up) begin
      step_digit = (sel_digit >= DigitMax) ? 4'd0 : sel_digit + 4'd1;
    end else begin
      step_digit = (sel_digit == 4'd0) ? DigitMax : sel_digit - 4'd1;
    end
    new_ones = digit_sel_q ? step_digit : cur_ones;
    new_tens = digit_sel_q ? cur_tens : step_digit;
    cand     = join_digits(new_tens, new_ones);
  end

  always_comb begin
    mode_d       = mode_q;
    digit_sel_d  = digit_sel_q;
    limit_high_d = limit_high_q;
    limit_low_d  = limit_low_q;
    shown_d      = shown_q;
    led_a_d      = led_a_q;
    led_b_d      = led_b_q;
    buzzer_d     = buzzer_q;
    upd          = 1'b0;

    if (func_e'(func_q) == FUNC_SAMPLE) begin
      if (mode_q == MODE_NORMAL) begin
        shown_d  = (deg_q > {1'b0, DisplayMax}) ? DisplayMax : deg_q[ValW-1:0];
        upd      = 1'b1;
        buzzer_d = (deg_q > {1'b0, limit_high_q}) || (deg_q < {1'b0, limit_low_q});
        led_a_d  = !led_a_q;
        led_b_d  = !led_b_q;
      end
    end else if (pressed_q) begin
      unique case (func_e'(func_q))
        FUNC_MODE_KEY: begin
          digit_sel_d = 1'b1;
          unique case (mode_q)
            MODE_NORMAL: begin
              mode_d  = MODE_EDIT_HIGH;
              led_a_d = 1'b1;
              led_b_d = 1'b0;
              shown_d = limit_high_q;
              upd     = 1'b1;
            end
            MODE_EDIT_HIGH: begin
              mode_d  = MODE_EDIT_LOW;
              led_a_d = 1'b0;
              led_b_d = 1'b1;
              shown_d = limit_low_q;
              upd     = 1'b1;
            end
            default: begin
              // Edit low returns to normal; the shown number stays.
              mode_d  = MODE_NORMAL;
              led_a_d = 1'b0;
              led_b_d = 1'b0;
            end
          endcase
        end
        FUNC_SEL_KEY: begin
          if (mode_q != MODE_NORMAL) begin
            digit_sel_d = !digit_sel_q;
          end
        end
        FUNC_INC_KEY, FUNC_DEC_KEY: begin
          if (mode_q == MODE_EDIT_HIGH) begin
            // An edit that would put high below low is dropped, but the
            // display is still rewritten with the kept limit.
            limit_high_d = (cand >= limit_low_q) ? cand : limit_high_q;
            shown_d      = limit_high_d;
            upd          = 1'b1;
          end else if (mode_q == MODE_EDIT_LOW) begin
            limit_low_d = (cand <= limit_high_q) ? cand : limit_low_q;
            shown_d     = limit_low_d;
            upd         = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_NORMAL;
      digit_sel_q  <= 1'b0;
      limit_high_q <= LimitHighRst;
      limit_low_q  <= LimitLowRst;
      shown_q      <= '0;
      led_a_q      <= 1'b0;
      led_b_q      <= 1'b0;
      buzzer_q     <= 1'b0;
    end else if (advance) begin
      mode_q       <= mode_d;
      digit_sel_q  <= digit_sel_d;
      limit_high_q <= limit_high_d;
      limit_low_q  <= limit_low_d;
      shown_q      <= shown_d;
      led_a_q      <= led_a_d;
      led_b_q      <= led_b_d;
      buzzer_q     <= buzzer_d;
    end
  end

  // ---------------- result register ----------------
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  assign out_data_d = {1'b0, buzzer_d, led_b_d, led_a_d, (mode_d != MODE_NORMAL),
                       digit_sel_d, mode_d, upd, shown_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_limits_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_high_q >= limit_low_q)
    else $error("high limit fell below low limit");

  a_limits_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (limit_high_q <= DisplayMax) && (shown_q <= DisplayMax))
    else $error("limit or shown value above 99");

  a_leds_match_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_NORMAL) |-> (led_a_q == led_b_q))
    else $error("LEDs out of step in normal mode");

  a_blink_follows_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11] == (m_axis_tdata[9:8] != MODE_NORMAL)))
    else $error("blink flag disagrees with reported mode");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled while its stage is empty");
`endif

endmodule

// File: dv/temp_alarm_threshold_editor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_alarm_threshold_editor_checker: panel status predictor and comparator
// Watches both stream channels and follows the panel state for every input
// transfer. It checks each status transfer field by field against the
// oldest predicted status.
// ----------------------------------------------------------------------------
module temp_alarm_threshold_editor_checker
  import tate_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // pressed, temp_milli[17:0], pad
  input  logic [FuncW-1:0]    s_axis_tuser,   // func[2:0]
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,   // display_value[6:0], display_updated,
                                              // edit_mode[1:0], blink_digit, blink_on,
                                              // led_a, led_b, alarm, pad
  output int                  fail_cnt_o,
  output int                  pending_o
);

  localparam int MaxReports = 10;

  // Status word, highest bit first.
  typedef struct packed {
    logic            pad;
    logic            alarm;
    logic            led_b;
    logic            led_a;
    logic            blink_on;
    logic            blink_digit;
    logic [1:0]      edit_mode;
    logic            display_updated;
    logic [ValW-1:0] display_value;
  } panel_status_t;

  mode_e           mode_q;
  logic            ones_sel_q;
  logic [ValW-1:0] limit_high_q;
  logic [ValW-1:0] limit_low_q;
  logic [ValW-1:0] shown_q;
  logic            led_a_q;
  logic            led_b_q;
  logic            buzzer_q;

  panel_status_t   panel_status_q[$];
  int              fail_cnt = 0;
  int              pending_cnt = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending_cnt;

  function automatic void note_mismatch(string what, int exp_v, int act_v);
    if (fail_cnt < MaxReports) begin
      $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
    end
    fail_cnt++;
  endfunction

  // Increment or decrement the selected digit of the limit being edited.
  // The new value is dropped when it would put the high limit below the low one.
  task automatic edit_limit(input bit up, output logic upd);
    int cur;
    int ones;
    int tens;
    int cand;
    upd = 1'b0;
    if (mode_q == MODE_EDIT_HIGH || mode_q == MODE_EDIT_LOW) begin
      cur  = (mode_q == MODE_EDIT_HIGH) ? limit_high_q : limit_low_q;
      ones = cur % 10;
      tens = (cur / 10) % 10;
      if (ones_sel_q) begin
        ones = up ? (ones + 1) % 10 : (ones + 9) % 10;
      end else begin
        tens = up ? (tens + 1) % 10 : (tens + 9) % 10;
      end
      cand = tens * 10 + ones;
      if (mode_q == MODE_EDIT_HIGH) begin
        if (cand >= limit_low_q) limit_high_q = ValW'(cand);
        shown_q = limit_high_q;
      end else begin
        if (cand <= limit_high_q) limit_low_q = ValW'(cand);
        shown_q = limit_low_q;
      end
      upd = 1'b1;
    end
  endtask

  task automatic panel_step(input logic [FuncW-1:0] func, input logic pressed,
                            input logic [TempW-1:0] temp_raw);
    panel_status_t st;
    logic          upd;
    int            deg;
    upd = 1'b0;
    if (func == FUNC_SAMPLE) begin
      if (mode_q == MODE_NORMAL) begin
        deg = $signed(temp_raw);
        if (deg < 0) deg = -deg;
        deg = deg / 1000;
        // The alarm compares the whole degrees before the display clamp.
        shown_q  = (deg > DisplayMax) ? DisplayMax : ValW'(deg);
        buzzer_q = (deg > limit_high_q) || (deg < limit_low_q);
        led_a_q  = ~led_a_q;
        led_b_q  = ~led_b_q;
        upd      = 1'b1;
      end
    end else if (pressed) begin
      case (func)
        FUNC_MODE_KEY: begin
          ones_sel_q = 1'b1;
          case (mode_q)
            MODE_NORMAL: begin
              mode_q  = MODE_EDIT_HIGH;
              led_a_q = 1'b1;
              led_b_q = 1'b0;
              shown_q = limit_high_q;
              upd     = 1'b1;
            end
            MODE_EDIT_HIGH: begin
              mode_q  = MODE_EDIT_LOW;
              led_a_q = 1'b0;
              led_b_q = 1'b1;
              shown_q = limit_low_q;
              upd     = 1'b1;
            end
            default: begin
              mode_q  = MODE_NORMAL;
              led_a_q = 1'b0;
              led_b_q = 1'b0;
            end
          endcase
        end
        FUNC_INC_KEY: edit_limit(1'b1, upd);
        FUNC_DEC_KEY: edit_limit(1'b0, upd);
        FUNC_SEL_KEY: begin
          if (mode_q != MODE_NORMAL) ones_sel_q = ~ones_sel_q;
        end
        default: ;
      endcase
    end
    st.pad             = 1'b0;
    st.display_value   = shown_q;
    st.display_updated = upd;
    st.edit_mode       = mode_q;
    st.blink_digit     = ones_sel_q;
    st.blink_on        = (mode_q != MODE_NORMAL);
    st.led_a           = led_a_q;
    st.led_b           = led_b_q;
    st.alarm           = buzzer_q;
    panel_status_q.push_back(st);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    panel_status_t exp_st;
    panel_status_t act_st;
    if (!rst_ni) begin
      mode_q       = MODE_NORMAL;
      ones_sel_q   = 1'b0;
      limit_high_q = LimitHighRst;
      limit_low_q  = LimitLowRst;
      shown_q      = '0;
      led_a_q      = 1'b0;
      led_b_q      = 1'b0;
      buzzer_q     = 1'b0;
      panel_status_q.delete();
      pending_cnt  = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        panel_step(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[TempW:1]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act_st = m_axis_tdata;
        if (panel_status_q.size() == 0) begin
          if (fail_cnt < MaxReports) begin
            $display("[%0t] status transfer with nothing expected: tdata %h",
                     $time, m_axis_tdata);
          end
          fail_cnt++;
        end else begin
          exp_st = panel_status_q.pop_front();
          if (act_st.display_value != exp_st.display_value)
            note_mismatch("display_value", exp_st.display_value, act_st.display_value);
          if (act_st.display_updated != exp_st.display_updated)
            note_mismatch("display_updated", exp_st.display_updated,
                          act_st.display_updated);
          if (act_st.edit_mode != exp_st.edit_mode)
            note_mismatch("edit_mode", exp_st.edit_mode, act_st.edit_mode);
          if (act_st.blink_digit != exp_st.blink_digit)
            note_mismatch("blink_digit", exp_st.blink_digit, act_st.blink_digit);
          if (act_st.blink_on != exp_st.blink_on)
            note_mismatch("blink_on", exp_st.blink_on, act_st.blink_on);
          if (act_st.led_a != exp_st.led_a)
            note_mismatch("led_a", exp_st.led_a, act_st.led_a);
          if (act_st.led_b != exp_st.led_b)
            note_mismatch("led_b", exp_st.led_b, act_st.led_b);
          if (act_st.alarm != exp_st.alarm)
            note_mismatch("alarm", exp_st.alarm, act_st.alarm);
        end
      end
      pending_cnt = panel_status_q.size();
    end
  end

endmodule

// File: dv/tb_temp_alarm_threshold_editor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_temp_alarm_threshold_editor_top: testbench of the temperature alarm panel
// Drives samples and key presses with random gaps on both channels, first a
// directed sequence through every key and edit case, then random edit
// sessions and samples. The checker predicts and compares every status.
// ----------------------------------------------------------------------------
module tb_temp_alarm_threshold_editor_top;
  import tate_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 8;
  localparam int PhaseItems = 390;
  // Function codes the block does not define; they must leave the state alone.
  localparam logic [FuncW-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FuncW-1:0] FUNC_SPARE_HI = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [FuncW-1:0]    s_axis_tuser = '0;
  logic                m_axis_tready = 1'b0;
  wire                 s_axis_tready;
  wire                 m_axis_tvalid;
  wire  [OutDataW-1:0] m_axis_tdata;

  int tx_idle_pct = 27;
  int rx_idle_pct = 83;
  int idle_cycles = 0;
  int fail_cnt;
  int pending;

  always #4 clk_i = ~clk_i;

  temp_alarm_threshold_editor_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  temp_alarm_threshold_editor_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Ends a hung run: too many cycles without a transfer on either channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input logic [FuncW-1:0] func, input logic pressed,
                           input logic [TempW-1:0] temp);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {{(InDataW-TempW-1){1'b0}}, temp, pressed};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_sample(input int milli);
    send_item(FUNC_SAMPLE, 1'($urandom_range(1)), TempW'(milli));
  endtask

  task automatic send_key(input logic [FuncW-1:0] func);
    send_item(func, 1'b1, TempW'($urandom));
  endtask

  // Mostly samples and edit keys so that edit sessions run long enough to
  // walk the limits across their whole range; a few spare codes and
  // released keys mixed in.
  task automatic send_random_item();
    int               pick;
    int               milli;
    logic [FuncW-1:0] func;
    pick = $urandom_range(99);
    if (pick < 35) begin
      case ($urandom_range(3))
        0:       milli = int'($urandom_range(180000)) - 55000;
        1:       milli = int'($urandom);
        default: begin
          milli = int'($urandom_range(99)) * 1000 + int'($urandom_range(999));
          if ($urandom_range(1)) milli = -milli;
        end
      endcase
      send_sample(milli);
    end else begin
      if (pick < 45)      func = FUNC_MODE_KEY;
      else if (pick < 65) func = FUNC_INC_KEY;
      else if (pick < 85) func = FUNC_DEC_KEY;
      else if (pick < 95) func = FUNC_SEL_KEY;
      else                func = FuncW'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
      send_item(func, ($urandom_range(9) != 0), TempW'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Samples in normal mode: extremes of the field and the limit boundaries.
    send_item(FUNC_SAMPLE, 1'b0, '0);
    send_sample(125000);
    send_sample(-55000);
    send_sample(-131072);
    send_sample(131071);
    send_sample(25000);
    send_sample(24999);
    send_sample(30999);
    send_sample(31000);

    // Keys that do nothing in normal mode, a released key and spare codes.
    send_key(FUNC_INC_KEY);
    send_key(FUNC_DEC_KEY);
    send_key(FUNC_SEL_KEY);
    send_item(FUNC_MODE_KEY, 1'b0, '1);
    for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++) send_key(FuncW'(f));

    // Edit the high limit, including a rejected change, then the low limit.
    send_key(FUNC_MODE_KEY);
    send_sample(45000);
    send_key(FUNC_INC_KEY);
    send_key(FUNC_SEL_KEY);
    send_key(FUNC_DEC_KEY);
    send_key(FUNC_INC_KEY);
    send_key(FUNC_MODE_KEY);
    send_key(FUNC_DEC_KEY);
    send_key(FUNC_SEL_KEY);
    send_key(FUNC_INC_KEY);
    send_key(FUNC_INC_KEY);
    send_key(FUNC_MODE_KEY);
    send_sample(40000);

    repeat (PhaseItems) send_random_item();
    tx_idle_pct = 83;
    rx_idle_pct = 27;
    repeat (PhaseItems) send_random_item();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (PhaseItems) send_random_item();

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
